>>> design/sdcf_pkg.sv
// Shared types, constants and CRC7 helper for the SD SPI command framer.
package sdcf_pkg;

	localparam int unsigned QueueDepthDefault = 2;

	localparam logic [7:0] StartBit  = 8'h40;
	localparam logic [7:0] CrcIdx0   = 8'h95;
	localparam logic [7:0] CrcIdx8   = 8'h87;
	localparam logic [7:0] StuffByte = 8'hFF;
	localparam logic [6:0] Crc7Poly  = 7'h09;

	localparam logic [5:0] IdxGoIdle  = 6'd0;
	localparam logic [5:0] IdxIfCond  = 6'd8;
	localparam logic [5:0] IdxStopTx  = 6'd12;

	localparam logic [2:0] PosStart = 3'd0;
	localparam logic [2:0] PosArg3  = 3'd1;
	localparam logic [2:0] PosArg2  = 3'd2;
	localparam logic [2:0] PosArg1  = 3'd3;
	localparam logic [2:0] PosArg0  = 3'd4;
	localparam logic [2:0] PosCrc   = 3'd5;
	localparam logic [2:0] PosStuff = 3'd6;

	typedef enum logic [1:0] {
		CRC_CALC,
		CRC_FORCE0,
		CRC_FORCE8
	} crc_sel_t;

	typedef struct packed {
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		crc_sel_t    crc_sel;
		logic        stuff;
	} cmd_entry_t;

	function automatic logic [6:0] crc7_feed(input logic [6:0] crc, input logic [7:0] data);
		logic [6:0] c;
		logic       fb;
		c = crc;
		for (int b = 7; b >= 0; b--) begin
			fb = c[6] ^ data[b];
			c = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ Crc7Poly;
			end
		end
		return c;
	endfunction

endpackage

>>> design/sdcf_front.sv
// Front stage: takes command transfers and classifies CRC handling and stuffing.
module sdcf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [5:0]           cmd_index,
	input  logic [31:0]          cmd_argument,
	output logic                 push,
	input  logic                 full,
	output sdcf_pkg::cmd_entry_t entry
);

	logic                 valid_s1;
	sdcf_pkg::cmd_entry_t entry_s1;
	sdcf_pkg::crc_sel_t   sel;

	assign cmd_stall = valid_s1 && full;
	assign push      = valid_s1 && !full;
	assign entry     = entry_s1;

	always_comb begin
		priority if (cmd_index == sdcf_pkg::IdxGoIdle) begin
			sel = sdcf_pkg::CRC_FORCE0;
		end else if (cmd_index == sdcf_pkg::IdxIfCond) begin
			sel = sdcf_pkg::CRC_FORCE8;
		end else begin
			sel = sdcf_pkg::CRC_CALC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			entry_s1.cmd_index    <= cmd_index;
			entry_s1.cmd_argument <= cmd_argument;
			entry_s1.crc_sel      <= sel;
			entry_s1.stuff        <= (cmd_index == sdcf_pkg::IdxStopTx);
		end
	end

endmodule

>>> design/sdcf_queue.sv
// Small FIFO between the classifying front and the byte sequencer.
module sdcf_queue #(
	parameter int unsigned DEPTH = sdcf_pkg::QueueDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sdcf_pkg::cmd_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output sdcf_pkg::cmd_entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sdcf_pkg::cmd_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

>>> design/sdcf_back.sv
// Back end: sequences frame bytes one per cycle while not stalled and accumulates the CRC7.
module sdcf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  sdcf_pkg::cmd_entry_t head,
	output logic                 pop,
	output logic                 frame_valid,
	input  logic                 frame_stall,
	output logic [7:0]           frame_byte,
	output logic                 last_byte
);

	logic                 busy_q;
	logic [2:0]           pos_q;
	logic [6:0]           crc_q;
	sdcf_pkg::cmd_entry_t cur_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	sdcf_pkg::cmd_entry_t src;
	logic [2:0]           pos;
	logic [6:0]           crc_in;
	logic [6:0]           crc_next;
	logic [7:0]           next_byte;
	logic                 next_last;
	logic                 advance;
	logic                 emit;

	assign advance = !out_valid_q || !frame_stall;
	assign emit    = advance && (busy_q || !empty);
	assign pop     = advance && !busy_q && !empty;

	assign src    = busy_q ? cur_q : head;
	assign pos    = busy_q ? pos_q : sdcf_pkg::PosStart;
	assign crc_in = busy_q ? crc_q : 7'd0;

	always_comb begin
		next_last = 1'b0;
		unique case (pos)
			sdcf_pkg::PosStart: next_byte = sdcf_pkg::StartBit | {2'b00, src.cmd_index};
			sdcf_pkg::PosArg3:  next_byte = src.cmd_argument[31:24];
			sdcf_pkg::PosArg2:  next_byte = src.cmd_argument[23:16];
			sdcf_pkg::PosArg1:  next_byte = src.cmd_argument[15:8];
			sdcf_pkg::PosArg0:  next_byte = src.cmd_argument[7:0];
			sdcf_pkg::PosCrc: begin
				next_last = !src.stuff;
				unique case (src.crc_sel)
					sdcf_pkg::CRC_FORCE0: next_byte = sdcf_pkg::CrcIdx0;
					sdcf_pkg::CRC_FORCE8: next_byte = sdcf_pkg::CrcIdx8;
					default:              next_byte = {crc_q, 1'b1};
				endcase
			end
			default: begin
				next_byte = sdcf_pkg::StuffByte;
				next_last = 1'b1;
			end
		endcase
	end

	assign crc_next = sdcf_pkg::crc7_feed(crc_in, next_byte);

	assign frame_valid = out_valid_q;
	assign frame_byte  = out_byte_q;
	assign last_byte   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= sdcf_pkg::PosStart;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
			if (emit) begin
				busy_q <= !next_last;
				pos_q  <= pos + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			crc_q      <= crc_next;
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

endmodule

>>> design/sd_spi_command_framer_unit.sv
// Top level of the SD SPI command framer: front, queue and byte sequencer.
// Each command transfer (index and 32-bit argument) becomes an SPI-mode frame
// of six bytes, or seven for index 12 with its trailing 0xFF stuff byte; the
// final byte has last_byte set. The back-end sequencer puts out one byte per
// cycle while frame_stall is low and computes the CRC7 byte by byte as the
// frame goes out; the front stage and the queue let further commands
// transfer in while a frame is still being sent.
module sd_spi_command_framer_unit #(
	parameter int unsigned QUEUE_DEPTH = sdcf_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [5:0]  cmd_index,
	input  logic [31:0] cmd_argument,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	logic                 push;
	logic                 full;
	logic                 pop;
	logic                 empty;
	sdcf_pkg::cmd_entry_t push_entry;
	sdcf_pkg::cmd_entry_t head;

	sdcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd_index    (cmd_index),
		.cmd_argument (cmd_argument),
		.push         (push),
		.full         (full),
		.entry        (push_entry)
	);

	sdcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	sdcf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

endmodule

>>> bench/sdcf_frame_checker.sv
// Frame checker: predicts each command's byte stream and compares it with the output.
module sdcf_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  logic [5:0]  cmd_index,
	input  logic [31:0] cmd_argument,
	input  logic        frame_valid,
	input  logic        frame_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output int          fail_count,
	output int          bytes_pending,
	output int          bytes_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       last_flag;
	} frame_beat_t;

	frame_beat_t expected_beats[$];

	// CRC7 over start byte and argument, MSB first, end bit appended
	function automatic logic [7:0] crc_byte_of(input logic [39:0] head);
		logic [6:0] r;
		logic       fb;
		r = '0;
		for (int i = 39; i >= 0; i--) begin
			fb = r[6] ^ head[i];
			r = {r[5:0], 1'b0} ^ (fb ? sdcf_pkg::Crc7Poly : 7'h00);
		end
		return {r, 1'b1};
	endfunction

	task automatic queue_frame(input logic [5:0] idx, input logic [31:0] arg);
		logic [39:0] head;
		logic [7:0]  crc;
		head = {sdcf_pkg::StartBit | {2'b00, idx}, arg};
		crc = crc_byte_of(head);
		if (idx == sdcf_pkg::IdxGoIdle) begin
			crc = sdcf_pkg::CrcIdx0;
		end else if (idx == sdcf_pkg::IdxIfCond) begin
			crc = sdcf_pkg::CrcIdx8;
		end
		for (int k = 4; k >= 0; k--) begin
			expected_beats.push_back({head[k*8 +: 8], 1'b0});
		end
		expected_beats.push_back({crc, idx != sdcf_pkg::IdxStopTx});
		if (idx == sdcf_pkg::IdxStopTx) begin
			expected_beats.push_back({sdcf_pkg::StuffByte, 1'b1});
		end
	endtask

	initial begin
		fail_count = 0;
		bytes_pending = 0;
		bytes_checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		frame_beat_t exp_beat;
		if (!arst_n) begin
			expected_beats.delete();
			bytes_pending = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				queue_frame(cmd_index, cmd_argument);
			end
			if (frame_valid && !frame_stall) begin
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected frame byte %02h last %0d", frame_byte, last_byte);
					end
				end else begin
					exp_beat = expected_beats.pop_front();
					bytes_checked++;
					if (exp_beat.data !== frame_byte || exp_beat.last_flag !== last_byte) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("frame byte mismatch: expected %02h last %0d, got %02h last %0d",
								exp_beat.data, exp_beat.last_flag, frame_byte, last_byte);
						end
					end
				end
			end
			bytes_pending = expected_beats.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// Testbench top: clock, reset, command stimulus, output stall and the final verdict.
module tb_top;

	localparam int CycleLimit = 200000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [5:0]  cmd_index = '0;
	logic [31:0] cmd_argument = '0;
	logic        frame_valid;
	logic        frame_stall = 1'b0;
	logic [7:0]  frame_byte;
	logic        last_byte;

	int fail_count;
	int bytes_pending;
	int bytes_checked;
	int sender_idle_pct = 10;
	int receiver_idle_pct = 68;
	int cycle_count = 0;
	int commands_sent = 0;
	int special_sent = 0;

	sd_spi_command_framer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd_index   (cmd_index),
		.cmd_argument(cmd_argument),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

	sdcf_frame_checker frame_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd_index    (cmd_index),
		.cmd_argument (cmd_argument),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte),
		.fail_count   (fail_count),
		.bytes_pending(bytes_pending),
		.bytes_checked(bytes_checked)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		frame_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [5:0] pick_index();
		case ($urandom_range(9))
			0: return sdcf_pkg::IdxGoIdle;
			1: return sdcf_pkg::IdxIfCond;
			2: return sdcf_pkg::IdxStopTx;
			3: return 6'h3F;
			default: return 6'($urandom_range(63));
		endcase
	endfunction

	function automatic logic [31:0] pick_argument();
		case ($urandom_range(6))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h1 << $urandom_range(31);
			3: return ~(32'h1 << $urandom_range(31));
			default: return $urandom();
		endcase
	endfunction

	task automatic send_command(input logic [5:0] idx, input logic [31:0] arg);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_index <= idx;
		cmd_argument <= arg;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
		commands_sent++;
		if (idx == sdcf_pkg::IdxGoIdle || idx == sdcf_pkg::IdxIfCond ||
			idx == sdcf_pkg::IdxStopTx) begin
			special_sent++;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// field extremes, forced CRC indexes and the stuff byte
		send_command(sdcf_pkg::IdxGoIdle, 32'h0000_0000);
		send_command(sdcf_pkg::IdxGoIdle, 32'hFFFF_FFFF);
		send_command(sdcf_pkg::IdxIfCond, 32'h0000_01AA);
		send_command(sdcf_pkg::IdxIfCond, 32'h0000_0000);
		send_command(sdcf_pkg::IdxStopTx, 32'h0000_0000);
		send_command(sdcf_pkg::IdxStopTx, 32'hFFFF_FFFF);
		send_command(6'h3F, 32'hFFFF_FFFF);
		send_command(6'h3F, 32'h0000_0000);
		send_command(6'd1, 32'h0000_0000);
		send_command(6'd17, 32'h8000_0000);
		send_command(6'd55, 32'h0000_0001);
		send_command(6'd24, 32'hA5A5_5A5A);
		send_command(6'd41, 32'h40FF_8000);
		send_command(6'd58, 32'h0000_8000);
		send_command(6'd7, 32'h5555_AAAA);
		send_command(sdcf_pkg::IdxStopTx, 32'h1234_5678);
		send_command(sdcf_pkg::IdxGoIdle, 32'hDEAD_BEEF);
		send_command(6'd42, 32'h0F0F_F0F0);

		for (int n = 0; n < 142; n++) begin
			if (n == 47) begin
				sender_idle_pct = 68;
				receiver_idle_pct = 10;
			end else if (n == 95) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			send_command(pick_index(), pick_argument());
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (bytes_pending != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);

		$display("Covered %0d command transfers, %0d with index 0, 8 or 12, under mixed stalls.",
			commands_sent, special_sent);
		$display("Compared %0d frame bytes with the prediction, %0d mismatches.",
			bytes_checked, fail_count);
		if (fail_count == 0 && bytes_pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
